[rtl/i2c_register_master_top_macros.svh]
// assertion macros for the i2c register master checker
// expects a signal named clk, and rst_n for I2CRM_ASSERT, in the scope of each use
`ifndef I2C_REGISTER_MASTER_TOP_MACROS_SVH
`define I2C_REGISTER_MASTER_TOP_MACROS_SVH

// checked on every rising edge once reset is released
`define I2CRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, also during reset
`define I2CRM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/i2crm_pkg.sv]
// package of the i2c register master: request and result types, command codes
// and register reset values; used by the top level and the checker
`timescale 1ns / 1ps

package i2crm_pkg;

  // request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0]  ACK_WAIT_LIMIT_RST  = 8'd5;
  localparam logic [15:0] TICKS_PER_PHASE_RST = 16'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_last;
    logic       nack_error;
  } out_t;

endpackage

[rtl/i2c_register_master_top.sv]
// i2c register master: line sequencer, apb register file and handshake stages
// depends on i2crm_pkg
`timescale 1ns / 1ps

// Usage
//   in_*  : one request per item. kind tick advances the line sequencer by one
//           time tick and carries the sampled sda level; kind write or read starts
//           a register transaction when the master is idle and is dropped when busy.
//   out_* : exactly one result per request, the line levels and status after it,
//           plus a received byte with its last flag when one completes on that tick.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready : apb registers,
//           0x0 ack_wait_limit, 0x4 ticks_per_phase; pready is always high.
// A request passes the input register and then the result register, with the
// sequencer updated in between.
// Throughput is one request per cycle while out_ready is high; the sequencer
// state is a single register set, so back-to-back requests need no stall.
// When out_ready is low the result register holds and the input register fills;
// in_ready drops only when both are full.
// Reset (rst_n low, synchronous) empties both stages, idles the lines and returns
// the registers to 5 and 1.

module i2c_register_master_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  i2crm_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output i2crm_pkg::out_t  out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'd0,
    ST_S0   = 5'd1,
    ST_S1   = 5'd2,
    ST_S2   = 5'd3,
    ST_SPRE = 5'd4,
    ST_TX0  = 5'd5,
    ST_TX1  = 5'd6,
    ST_TX2  = 5'd7,
    ST_TX3  = 5'd8,
    ST_AL   = 5'd9,
    ST_AH   = 5'd10,
    ST_AE   = 5'd11,
    ST_RX0  = 5'd12,
    ST_RX1  = 5'd13,
    ST_RX2  = 5'd14,
    ST_RX3  = 5'd15,
    ST_MK0  = 5'd16,
    ST_MK1  = 5'd17,
    ST_MK2  = 5'd18,
    ST_MK3  = 5'd19,
    ST_P0   = 5'd20,
    ST_P1   = 5'd21,
    ST_P2   = 5'd22
  } state_t;

  // byte position within a transaction
  localparam logic [2:0] STG_ADDR  = 3'd0;
  localparam logic [2:0] STG_REG   = 3'd1;
  localparam logic [2:0] STG_DATA  = 3'd2;
  localparam logic [2:0] STG_RADDR = 3'd3;
  localparam logic [2:0] STG_RX    = 3'd4;

  localparam logic REG_ACK_LIMIT = 1'b0;
  localparam logic REG_TPP       = 1'b1;

  // configuration
  logic [7:0]  ack_limit_r;
  logic [15:0] tpp_r;

  // handshake stages
  logic            s1_valid_r;
  i2crm_pkg::in_t  s1_data_r;
  logic            out_valid_r;
  i2crm_pkg::out_t out_data_r;
  logic            fire;

  // sequencer state
  state_t      st_r,        st_nxt;
  logic [3:0]  bit_cnt_r,   bit_cnt_nxt;
  logic [7:0]  shift_r,     shift_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  ack_cnt_r,   ack_cnt_nxt;
  logic [15:0] timer_r,     timer_nxt;
  logic        cmd_rd_r,    cmd_rd_nxt;
  logic [7:0]  cmd_slave_r, cmd_slave_nxt;
  logic [7:0]  cmd_reg_r,   cmd_reg_nxt;
  logic [7:0]  cmd_data_r,  cmd_data_nxt;
  logic [2:0]  stage_r,     stage_nxt;
  logic        nack_r,      nack_nxt;

  logic        rxv;
  logic [7:0]  rxd;
  logic        rxl;
  logic [15:0] tpp_eff;
  logic        phase_end;
  logic [3:0]  bit_inc;
  logic [7:0]  bytes_dec;
  logic        cfg_wr;
  i2crm_pkg::out_t res;

  assign fire      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_ACK_LIMIT: prdata = {24'd0, ack_limit_r};
      REG_TPP:       prdata = {16'd0, tpp_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign tpp_eff   = (tpp_r == 16'd0) ? 16'd1 : tpp_r;
  assign phase_end = ({1'b0, timer_r} + 17'd1) >= {1'b0, tpp_eff};
  assign bit_inc   = bit_cnt_r + 4'd1;
  assign bytes_dec = (bytes_left_r != 8'd0) ? bytes_left_r - 8'd1 : 8'd0;

  always_comb begin
    st_nxt         = st_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    ack_cnt_nxt    = ack_cnt_r;
    timer_nxt      = timer_r;
    cmd_rd_nxt     = cmd_rd_r;
    cmd_slave_nxt  = cmd_slave_r;
    cmd_reg_nxt    = cmd_reg_r;
    cmd_data_nxt   = cmd_data_r;
    stage_nxt      = stage_r;
    nack_nxt       = nack_r;
    rxv            = 1'b0;
    rxd            = 8'd0;
    rxl            = 1'b0;

    if (s1_data_r.kind == i2crm_pkg::KIND_TICK) begin
      if (st_r == ST_AH) begin
        // acknowledge wait does not use the phase timer
        if (!s1_data_r.sda_in) begin
          ack_cnt_nxt = 8'd0;
          timer_nxt   = 16'd0;
          st_nxt      = ST_AE;
        end else if (ack_cnt_r >= ack_limit_r) begin
          ack_cnt_nxt = 8'd0;
          timer_nxt   = 16'd0;
          nack_nxt    = 1'b1;
          st_nxt      = ST_P0;
        end else begin
          ack_cnt_nxt = ack_cnt_r + 8'd1;
        end
      end else if (st_r != ST_IDLE) begin
        if (!phase_end) begin
          timer_nxt = timer_r + 16'd1;
        end else begin
          timer_nxt = 16'd0;
          case (st_r)
            ST_S0: st_nxt = ST_S1;
            ST_S1: st_nxt = ST_S2;
            ST_S2: begin
              bit_cnt_nxt = 4'd0;
              st_nxt      = ST_TX0;
              if (stage_r == STG_DATA) begin
                stage_nxt = STG_RADDR;
                shift_nxt = cmd_slave_r + 8'd1;
              end else begin
                stage_nxt = STG_ADDR;
                shift_nxt = cmd_slave_r;
              end
            end
            ST_SPRE: st_nxt = ST_S0;
            ST_TX0:  st_nxt = ST_TX1;
            ST_TX1:  st_nxt = ST_TX2;
            ST_TX2:  st_nxt = ST_TX3;
            ST_TX3: begin
              shift_nxt   = {shift_r[6:0], 1'b0};
              bit_cnt_nxt = bit_inc;
              st_nxt      = (bit_inc >= 4'd8) ? ST_AL : ST_TX0;
            end
            ST_AL: begin
              st_nxt      = ST_AH;
              ack_cnt_nxt = 8'd0;
            end
            ST_AE: begin
              case (stage_r)
                STG_ADDR: begin
                  stage_nxt   = STG_REG;
                  shift_nxt   = cmd_reg_r;
                  bit_cnt_nxt = 4'd0;
                  st_nxt      = ST_TX0;
                end
                STG_REG: begin
                  stage_nxt = STG_DATA;
                  if (cmd_rd_r) begin
                    st_nxt = ST_SPRE;
                  end else begin
                    shift_nxt   = cmd_data_r;
                    bit_cnt_nxt = 4'd0;
                    st_nxt      = ST_TX0;
                  end
                end
                STG_RADDR: begin
                  stage_nxt   = STG_RX;
                  shift_nxt   = 8'd0;
                  bit_cnt_nxt = 4'd0;
                  st_nxt      = ST_RX0;
                end
                default: st_nxt = ST_P0;
              endcase
            end
            ST_RX0: st_nxt = ST_RX1;
            ST_RX1: st_nxt = ST_RX2;
            ST_RX2: begin
              // sample on the last tick of the second high phase
              shift_nxt = {shift_r[6:0], s1_data_r.sda_in};
              st_nxt    = ST_RX3;
            end
            ST_RX3: begin
              bit_cnt_nxt = bit_inc;
              if (bit_inc >= 4'd8) begin
                rxv    = 1'b1;
                rxd    = shift_r;
                rxl    = (bytes_left_r <= 8'd1);
                st_nxt = ST_MK0;
              end else begin
                st_nxt = ST_RX0;
              end
            end
            ST_MK0: st_nxt = ST_MK1;
            ST_MK1: st_nxt = ST_MK2;
            ST_MK2: st_nxt = ST_MK3;
            ST_MK3: begin
              bytes_left_nxt = bytes_dec;
              if (bytes_dec == 8'd0) begin
                st_nxt = ST_P0;
              end else begin
                shift_nxt   = 8'd0;
                bit_cnt_nxt = 4'd0;
                st_nxt      = ST_RX0;
              end
            end
            ST_P0:   st_nxt = ST_P1;
            ST_P1:   st_nxt = ST_P2;
            ST_P2:   st_nxt = ST_IDLE;
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
    end else if ((s1_data_r.kind == i2crm_pkg::KIND_WRITE ||
                  s1_data_r.kind == i2crm_pkg::KIND_READ) && st_r == ST_IDLE) begin
      cmd_rd_nxt     = (s1_data_r.kind == i2crm_pkg::KIND_READ);
      cmd_slave_nxt  = s1_data_r.slave_addr;
      cmd_reg_nxt    = s1_data_r.reg_addr;
      cmd_data_nxt   = s1_data_r.write_data;
      bytes_left_nxt = (s1_data_r.read_count == 8'd0) ? 8'd1 : s1_data_r.read_count;
      stage_nxt      = STG_ADDR;
      bit_cnt_nxt    = 4'd0;
      shift_nxt      = 8'd0;
      ack_cnt_nxt    = 8'd0;
      timer_nxt      = 16'd0;
      nack_nxt       = 1'b0;
      st_nxt         = ST_S0;
    end
  end

  // line levels follow the state after the request
  always_comb begin
    res            = '0;
    res.scl_level  = 1'b1;
    res.sda_out    = 1'b1;
    res.sda_drive  = 1'b0;
    case (st_nxt)
      ST_S0: begin
        res.sda_drive = 1'b1;
      end
      ST_S1: begin
        res.sda_out   = 1'b0;
        res.sda_drive = 1'b1;
      end
      ST_S2, ST_P0: begin
        res.scl_level = 1'b0;
        res.sda_out   = 1'b0;
        res.sda_drive = 1'b1;
      end
      ST_SPRE: begin
        res.scl_level = 1'b0;
        res.sda_drive = 1'b1;
      end
      ST_TX0, ST_TX3: begin
        res.scl_level = 1'b0;
        res.sda_out   = shift_nxt[7];
        res.sda_drive = 1'b1;
      end
      ST_TX1, ST_TX2: begin
        res.sda_out   = shift_nxt[7];
        res.sda_drive = 1'b1;
      end
      ST_AL, ST_AE, ST_RX0, ST_RX3: begin
        res.scl_level = 1'b0;
      end
      ST_MK0, ST_MK3: begin
        res.scl_level = 1'b0;
        res.sda_out   = !(bytes_left_nxt > 8'd1);
        res.sda_drive = 1'b1;
      end
      ST_MK1, ST_MK2: begin
        res.sda_out   = !(bytes_left_nxt > 8'd1);
        res.sda_drive = 1'b1;
      end
      ST_P1: begin
        res.sda_out   = 1'b0;
        res.sda_drive = 1'b1;
      end
      ST_P2: begin
        res.sda_drive = 1'b1;
      end
      default: begin
        res.scl_level = 1'b1;
      end
    endcase
    res.busy_res   = (st_nxt != ST_IDLE);
    res.rx_valid   = rxv;
    res.rx_data    = rxd;
    res.rx_last    = rxl;
    res.nack_error = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_limit_r  <= i2crm_pkg::ACK_WAIT_LIMIT_RST;
      tpp_r        <= i2crm_pkg::TICKS_PER_PHASE_RST;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= ST_IDLE;
      bit_cnt_r    <= 4'd0;
      shift_r      <= 8'd0;
      bytes_left_r <= 8'd0;
      ack_cnt_r    <= 8'd0;
      timer_r      <= 16'd0;
      cmd_rd_r     <= 1'b0;
      cmd_slave_r  <= 8'd0;
      cmd_reg_r    <= 8'd0;
      cmd_data_r   <= 8'd0;
      stage_r      <= STG_ADDR;
      nack_r       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_ACK_LIMIT) begin
          ack_limit_r <= pwdata[7:0];
        end else begin
          tpp_r <= pwdata[15:0];
        end
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fire) begin
        st_r         <= st_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        shift_r      <= shift_nxt;
        bytes_left_r <= bytes_left_nxt;
        ack_cnt_r    <= ack_cnt_nxt;
        timer_r      <= timer_nxt;
        cmd_rd_r     <= cmd_rd_nxt;
        cmd_slave_r  <= cmd_slave_nxt;
        cmd_reg_r    <= cmd_reg_nxt;
        cmd_data_r   <= cmd_data_nxt;
        stage_r      <= stage_nxt;
        nack_r       <= nack_nxt;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

endmodule

[rtl/i2crm_checker.sv]
// port-level checker of the i2c register master and its bind to the top level
// depends on i2crm_pkg and i2c_register_master_top_macros.svh
`timescale 1ns / 1ps
`include "i2c_register_master_top_macros.svh"

module i2crm_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input i2crm_pkg::out_t out_data
);

  `I2CRM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `I2CRM_ASSERT(a_rx_busy, out_valid && out_data.rx_valid |-> out_data.busy_res && out_data.scl_level == 1'b0, "received byte outside a read")
  `I2CRM_ASSERT(a_rx_clear, out_valid && !out_data.rx_valid |-> out_data.rx_data == 8'd0 && !out_data.rx_last, "stale receive fields")
  `I2CRM_ASSERT(a_idle_lines, out_valid && !out_data.busy_res |-> out_data.scl_level && out_data.sda_out && !out_data.sda_drive, "lines not released when idle")
  `I2CRM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind i2c_register_master_top i2crm_checker u_i2crm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
